// ----- sv/rps_pkg.sv -----
// Shared constants, codes and types for the record page slot table.
// No dependencies.
package rps_pkg;

    localparam int SLOTS       = 64;
    localparam int RECORD_BITS = 64;
    localparam int ADDR_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = 7;
    localparam int KEY_W       = 32;
    localparam int WORD_W      = 64;

    typedef logic [1:0]        t_cmd;
    typedef logic [1:0]        t_status;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_cmd CMD_APPEND = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_DUMP   = 2'd2;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    localparam t_count SLOTS_CNT = CNT_W'(SLOTS);

    typedef struct packed {
        t_status status;
        t_word   record_out;
        logic    record_valid;
        t_count  record_count;
        t_count  free_slots;
        logic    last;
    } t_result;

endpackage

// ----- sv/rps_if.sv -----
// Handshake channels of the record page slot table: command items in, result items out.
// Depends on rps_pkg.
interface rps_in_if;
    logic                valid;
    logic                ready;
    rps_pkg::t_cmd       cmd;
    rps_pkg::t_word      record_word;
    logic signed [31:0]  record_key;

    modport source (output valid, output cmd, output record_word, output record_key,
                    input ready);
    modport sink   (input valid, input cmd, input record_word, input record_key,
                    output ready);
endinterface

interface rps_out_if;
    logic                valid;
    logic                ready;
    rps_pkg::t_status    status;
    rps_pkg::t_word      record_out;
    logic                record_valid;
    rps_pkg::t_count     record_count;
    rps_pkg::t_count     free_slots;
    logic                last;

    modport source (output valid, output status, output record_out, output record_valid,
                    output record_count, output free_slots, output last, input ready);
    modport sink   (input valid, input status, input record_out, input record_valid,
                    input record_count, input free_slots, input last, output ready);
endinterface

// ----- sv/rps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/rps_engine.sv -----
// Command sequencer: append, scan-and-shift remove, and dump over the slot RAM.
// Depends on rps_pkg and rps_ram.
module rps_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rps_pkg::t_cmd    i_cmd,
    input  rps_pkg::t_word   i_record_word,
    input  logic [31:0]      i_record_key,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output rps_pkg::t_result o_res
);
    import rps_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_SH_RD    = 3'd3;
    localparam logic [2:0] S_SH_WR    = 3'd4;
    localparam logic [2:0] S_D_RD     = 3'd5;
    localparam logic [2:0] S_D_CAP    = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    logic [2:0]             r_state, n_state;
    t_count                 r_count, n_count;
    t_count                 r_idx,   n_idx;
    logic [KEY_W-1:0]       r_key,   n_key;
    logic                   r_dump,  n_dump;
    t_status                r_status, n_status;
    t_word                  r_rec,   n_rec;
    logic                   r_rvld,  n_rvld;
    logic                   r_last,  n_last;

    logic                   we;
    logic [ADDR_W-1:0]      waddr, raddr;
    logic [RECORD_BITS-1:0] wdata, rdata;
    t_count                 idx_inc;

    assign idx_inc = r_idx + 7'd1;

    rps_ram #(.WIDTH(RECORD_BITS), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // shift reads one slot ahead of the write position
    assign raddr = (r_state == S_SH_RD) ? idx_inc[ADDR_W-1:0] : r_idx[ADDR_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_key    = r_key;
        n_dump   = r_dump;
        n_status = r_status;
        n_rec    = r_rec;
        n_rvld   = r_rvld;
        n_last   = r_last;
        we       = 1'b0;
        waddr    = r_idx[ADDR_W-1:0];
        wdata    = rdata;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_DONE;
                    n_rec    = '0;
                    n_rvld   = 1'b0;
                    n_last   = 1'b1;
                    n_dump   = 1'b0;
                    n_idx    = '0;
                    n_key    = i_record_key;
                    n_state  = S_RESP;
                    case (i_cmd)
                        CMD_APPEND: begin
                            if (r_count >= SLOTS_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                waddr   = r_count[ADDR_W-1:0];
                                wdata   = i_record_word[RECORD_BITS-1:0];
                                n_count = r_count + 7'd1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count != '0) begin
                                n_dump  = 1'b1;
                                n_state = S_D_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (rdata[KEY_W-1:0] == r_key) begin
                    n_state = S_SH_RD;
                end else if (idx_inc >= r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                if (idx_inc >= r_count) begin
                    n_count = r_count - 7'd1;
                    n_state = S_RESP;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                we      = 1'b1;
                n_idx   = idx_inc;
                n_state = S_SH_RD;
            end
            S_D_RD: begin
                n_state = S_D_CAP;
            end
            S_D_CAP: begin
                n_rec   = WORD_W'(rdata);
                n_rvld  = 1'b1;
                n_last  = (idx_inc == r_count);
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_res_ready) begin
                    if (r_dump && !r_last) begin
                        n_idx   = idx_inc;
                        n_state = S_D_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_dump  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_dump  <= n_dump;
        end
        r_key    <= n_key;
        r_status <= n_status;
        r_rec    <= n_rec;
        r_rvld   <= n_rvld;
        r_last   <= n_last;
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_RESP);
    assign o_res.status        = r_status;
    assign o_res.record_out    = r_rec;
    assign o_res.record_valid  = r_rvld;
    assign o_res.record_count  = r_count;
    assign o_res.free_slots    = SLOTS_CNT - r_count;
    assign o_res.last          = r_last;
endmodule

// ----- sv/record_page_slot_table.sv -----
// Top level of the record page slot table: sequencer plus output register.
// Depends on rps_pkg, rps_if (rps_in_if, rps_out_if) and rps_engine.
//
// A page of SLOTS fixed-size records kept packed from slot 0 upward.
// i_item carries one command item: cmd (append / remove by key / dump),
// record_word (record to append, low 32 bits are its key) and record_key.
// o_result carries result items; every item reports status, the record
// count and free slots after the command, and last marks the final result
// belonging to a command. Append, remove and unused commands give one
// result; dump gives one result per held record (record_valid set), or a
// single marker result on an empty page.
// One command is worked on at a time; i_item.ready is high only while the
// sequencer is idle. Remove scans slots from 0 for the key, then shifts
// each later record down one slot; scan and shift together visit each
// held slot once. Dump reads, captures and offers one record at a time.
// Each slot visit has an address state and a data state, as the slot RAM
// read data is registered.
// The output register holds a finished result while the receiver stalls;
// the sequencer keeps its next result pending and waits until taken.
// Reset (i_rst_n low, synchronous) empties the page at once: no clearing
// pass, slots above the count are never used.
module record_page_slot_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rps_in_if.sink    i_item,
    rps_out_if.source o_result
);
    import rps_pkg::*;

    logic    res_valid;
    logic    res_ready;
    t_result res;

    // output register
    logic    r_ovalid;
    t_result r_out;

    rps_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_item.valid),
        .o_in_ready    (i_item.ready),
        .i_cmd         (i_item.cmd),
        .i_record_word (i_item.record_word),
        .i_record_key  (i_item.record_key),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // register accepts a new result when empty or being drained this cycle
    assign res_ready = !r_ovalid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid        = r_ovalid;
    assign o_result.status       = r_out.status;
    assign o_result.record_out   = r_out.record_out;
    assign o_result.record_valid = r_out.record_valid;
    assign o_result.record_count = r_out.record_count;
    assign o_result.free_slots   = r_out.free_slots;
    assign o_result.last         = r_out.last;

    // count and free slots always add up to the page size
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (7'(o_result.record_count + o_result.free_slots) == SLOTS_CNT))
        else $error("record_count + free_slots differs from page size");

    // a dumped record only appears on a non-empty page with done status
    a_dump_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.record_valid) |->
            (o_result.status == ST_DONE && o_result.record_count != '0))
        else $error("dumped record with bad status or empty page");

    // a command is worked on alone: no second accept right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input accepted while previous command in progress");

    // error results never carry a record and are always last
    a_status_norec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_DONE) |->
            (!o_result.record_valid && o_result.last))
        else $error("error result carries a record or is not last");
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for record_page_slot_table: directed and random command items.
// A predictor of the packed record page produces the expected results.
// Depends on rps_pkg, rps_if (rps_in_if, rps_out_if) and record_page_slot_table.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rps_pkg::*;

    // The unused command code: the block answers it with a done marker
    // and leaves the page alone.
    localparam t_cmd CMD_UNUSED     = 2'd3;
    localparam int   RANDOM_ITEMS   = 160;
    localparam int   FILL_ITEMS     = 85;    // append-heavy stretch that fills the page
    localparam int   IDLE_PERCENT   = 22;
    localparam int   QUIET_FIRST    = 60;    // no idling on either side while
    localparam int   QUIET_LAST     = 110;   // the accepted count is in this range
    localparam int   DRAIN_CYCLES   = 300;   // longer than a full-page remove
    localparam int   WATCHDOG_LIMIT = 3000;

    // Records are stored only up to RECORD_BITS wide.
    localparam t_word RECORD_MASK = (RECORD_BITS >= WORD_W) ? '1
                                  : ((t_word'(1) << RECORD_BITS) - t_word'(1));

    typedef struct {
        t_cmd        cmd;
        t_word       word;
        logic [31:0] key;
    } t_page_op;

    logic i_clk;
    logic i_rst_n;

    rps_in_if  item_if ();
    rps_out_if result_if ();

    record_page_slot_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    t_page_op    pending_ops[$];   // items waiting for the driver
    t_word       plan_page[$];     // page as the stimulus generator expects it
    t_result     plan_scratch[$];
    t_word       model_page[$];    // page as the predictor tracks it
    t_result     results_due[$];   // expected results, oldest first
    t_page_op    drive_op;
    t_result     due_now;
    int          items_accepted;
    int          mismatch_count;
    int          stall_cycles;
    logic [31:0] key_pool [0:5] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678};

    // ---------------------------------------------------------------
    // Predictor. Applies one command to a page and appends the results
    // it causes. The page is a queue, so removal is a delete, which
    // gives the shift-down of every later record for free.
    // ---------------------------------------------------------------
    function automatic t_result page_result(int held, t_status st, t_word rec,
                                            logic rec_valid, logic is_last);
        t_result r;
        r.status       = st;
        r.record_out   = rec;
        r.record_valid = rec_valid;
        r.record_count = t_count'(held);
        r.free_slots   = t_count'(SLOTS - held);
        r.last         = is_last;
        return r;
    endfunction

    function automatic void page_apply(ref t_word page[$], ref t_result due[$],
                                       input t_cmd cmd, input t_word word,
                                       input logic [31:0] key);
        t_status st;
        int      hit;
        case (cmd)
            CMD_APPEND: begin
                if (page.size() >= SLOTS) begin
                    st = ST_FULL;
                end else begin
                    page.insert(page.size(), word & RECORD_MASK);
                    st = ST_DONE;
                end
                due.insert(due.size(), page_result(page.size(), st, '0, 1'b0, 1'b1));
            end
            CMD_REMOVE: begin
                // first match in slot order, key compared as a raw 32-bit pattern
                hit = -1;
                for (int i = 0; i < page.size() && hit < 0; i++) begin
                    if (page[i][31:0] == key) hit = i;
                end
                if (hit >= 0) begin
                    page.delete(hit);
                    st = ST_DONE;
                end else begin
                    st = ST_NOT_FOUND;
                end
                due.insert(due.size(), page_result(page.size(), st, '0, 1'b0, 1'b1));
            end
            CMD_DUMP: begin
                if (page.size() == 0) begin
                    due.insert(due.size(), page_result(0, ST_DONE, '0, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < page.size(); i++) begin
                        due.insert(due.size(),
                                   page_result(page.size(), ST_DONE, page[i], 1'b1,
                                               i == page.size() - 1));
                    end
                end
            end
            default: begin
                due.insert(due.size(), page_result(page.size(), ST_DONE, '0, 1'b0, 1'b1));
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers. The generator keeps its own page so it can aim
    // removes at keys that are really held.
    // ---------------------------------------------------------------
    task automatic queue_item(t_cmd cmd, t_word word, logic [31:0] key);
        t_page_op op;
        op.cmd  = cmd;
        op.word = word;
        op.key  = key;
        pending_ops.insert(pending_ops.size(), op);
        page_apply(plan_page, plan_scratch, cmd, word, key);
        plan_scratch.delete();
    endtask

    // Random record; about a third reuse a small key set so duplicates occur.
    function automatic t_word rand_record();
        logic [31:0] upper;
        logic [31:0] lower;
        upper = $urandom;
        lower = ($urandom_range(99) < 30) ? key_pool[$urandom_range(5)] : $urandom;
        return {upper, lower};
    endfunction

    task automatic queue_remove(bit held_key);
        logic [31:0] key;
        if (held_key && plan_page.size() != 0) begin
            key = plan_page[$urandom_range(plan_page.size() - 1)][31:0];
        end else begin
            key = $urandom;
        end
        queue_item(CMD_REMOVE, rand_record(), key);
    endtask

    // Idle roughly IDLE_PERCENT of cycles, except inside the quiet window.
    function automatic bit take_break();
        if (items_accepted >= QUIET_FIRST && items_accepted < QUIET_LAST) return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    // Clock, and known values on every input from time zero.
    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        item_if.valid        = 1'b0;
        item_if.cmd          = CMD_APPEND;
        item_if.record_word  = '0;
        item_if.record_key   = '0;
        result_if.ready      = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Driver. Holds an item until it is taken; the predictor runs on
    // the fields at the accepting edge.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                page_apply(model_page, results_due, item_if.cmd, item_if.record_word,
                           item_if.record_key);
                items_accepted++;
            end
            if (!item_if.valid || item_if.ready) begin
                if (pending_ops.size() != 0 && !take_break()) begin
                    drive_op             = pending_ops.pop_front();
                    item_if.valid       <= 1'b1;
                    item_if.cmd         <= drive_op.cmd;
                    item_if.record_word <= drive_op.word;
                    item_if.record_key  <= drive_op.key;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor. Each taken result is checked against the oldest expected one.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: status %0d record %h count %0d",
                           result_if.status, result_if.record_out, result_if.record_count);
                    mismatch_count++;
                end else begin
                    due_now = results_due.pop_front();
                    if (result_if.status !== due_now.status) begin
                        $error("status: expected %0d, got %0d", due_now.status,
                               result_if.status);
                        mismatch_count++;
                    end
                    if (result_if.record_out !== due_now.record_out) begin
                        $error("record_out: expected %h, got %h", due_now.record_out,
                               result_if.record_out);
                        mismatch_count++;
                    end
                    if (result_if.record_valid !== due_now.record_valid) begin
                        $error("record_valid: expected %0d, got %0d", due_now.record_valid,
                               result_if.record_valid);
                        mismatch_count++;
                    end
                    if (result_if.record_count !== due_now.record_count) begin
                        $error("record_count: expected %0d, got %0d", due_now.record_count,
                               result_if.record_count);
                        mismatch_count++;
                    end
                    if (result_if.free_slots !== due_now.free_slots) begin
                        $error("free_slots: expected %0d, got %0d", due_now.free_slots,
                               result_if.free_slots);
                        mismatch_count++;
                    end
                    if (result_if.last !== due_now.last) begin
                        $error("last: expected %0d, got %0d", due_now.last, result_if.last);
                        mismatch_count++;
                    end
                end
            end
            result_if.ready <= !take_break();
        end
    end

    // Watchdog: cycles with no item moving on either channel.
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ---------------------------------------------------------------
    initial begin
        int counted;
        int roll;
        bit filling;
        bit full_dumped;

        items_accepted = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        counted        = 0;
        full_dumped    = 1'b0;

        // Directed: empty-page cases, extreme records and keys, duplicate
        // keys, first / middle / last removal and the unused command.
        queue_item(CMD_DUMP,   '0, '0);                          // marker on empty page
        queue_item(CMD_REMOVE, '1, 32'h0000_0000);                // not found on empty
        queue_item(CMD_UNUSED, '1, 32'hFFFF_FFFF);
        queue_item(CMD_APPEND, 64'h0000_0000_0000_0000, '1);
        queue_item(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        queue_item(CMD_APPEND, 64'h0000_0001_8000_0000, '0);      // most negative key
        queue_item(CMD_APPEND, 64'hFFFF_FFFF_7FFF_FFFF, '0);      // most positive key
        queue_item(CMD_APPEND, 64'hA5A5_A5A5_0000_0000, '0);      // duplicate of key 0
        queue_item(CMD_DUMP,   '1, '1);
        queue_item(CMD_UNUSED, '0, '0);                          // page must not change
        queue_item(CMD_REMOVE, '0, 32'h0000_0000);               // first slot, shift all
        queue_item(CMD_REMOVE, '0, 32'h8000_0000);               // middle slot
        queue_item(CMD_REMOVE, '0, 32'h0BAD_F00D);               // no match
        queue_item(CMD_DUMP,   '0, '0);
        queue_item(CMD_REMOVE, '0, 32'hFFFF_FFFF);               // key -1 as a pattern
        queue_item(CMD_REMOVE, '0, 32'h0000_0000);               // the duplicate, now last
        queue_item(CMD_REMOVE, '0, 32'h7FFF_FFFF);               // page empty again
        queue_item(CMD_DUMP,   '0, '0);

        // Random: an append-heavy stretch that runs into page full, then a
        // remove-heavy stretch that drains it, with dumps and noise mixed in.
        while (counted < RANDOM_ITEMS) begin
            roll    = $urandom_range(99);
            filling = (counted < FILL_ITEMS);
            if (roll < 2) begin
                queue_item(CMD_UNUSED, rand_record(), $urandom);
            end else begin
                counted++;
                if (roll < (filling ? 6 : 7))
                    queue_item(CMD_DUMP, rand_record(), $urandom);
                else if (filling ? (roll < 10) : (roll >= 12))
                    queue_remove(filling ? ($urandom_range(1) == 1)
                                         : ($urandom_range(99) < 95));
                else
                    queue_item(CMD_APPEND, rand_record(), $urandom);
                // dump the whole page once the first time it fills
                if (plan_page.size() == SLOTS && !full_dumped) begin
                    queue_item(CMD_DUMP, rand_record(), $urandom);
                    full_dumped = 1'b1;
                    counted++;
                end
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || item_if.valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rps_pkg.sv
sv/rps_if.sv
sv/rps_ram.sv
sv/rps_engine.sv
sv/record_page_slot_table.sv
tb/testbench.sv
